### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the glyph slot cache RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GCSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GCSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/gcsc_pkg.sv
// ---------------------------------------------------------------------------
// gcsc_pkg
// Types and constants shared by the glyph code slot cache.
// ---------------------------------------------------------------------------
package gcsc_pkg;

  localparam int SLOT_COUNT = 120;
  localparam int CODE_W     = 16;
  localparam int SLOT_W     = 7;

  // Narrow codes are accepted from 0x20 up to but not including 0x20 + 144.
  localparam logic [CODE_W-1:0] NARROW_FIRST = 16'h0020;
  localparam logic [CODE_W-1:0] NARROW_END   = 16'h00B0;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    KIND_LOOKUP,
    KIND_REJECT,
    KIND_TICK
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CODE_W-1:0] code;
    logic              pause;
  } item_t;

  typedef struct packed {
    logic              hit_valid;
    logic [SLOT_W-1:0] slot_index;
    logic              needs_load;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_CMP
  } bk_state_e;

endpackage

### rtl/core/gcsc_front.sv
// ---------------------------------------------------------------------------
// gcsc_front
// Accepts command words and classifies them as lookup, reject or tick.
// ---------------------------------------------------------------------------
module gcsc_front (
  input  logic                          start_i,
  input  logic                          mode_i,
  input  logic [gcsc_pkg::CODE_W-1:0]   char_code_i,
  input  logic                          pause_open_i,
  input  logic                          wide_mode_i,
  input  logic                          q_full_i,
  output logic                          busy_o,
  output logic                          push_o,
  output gcsc_pkg::item_t               item_o
);

  logic out_of_range;

  assign out_of_range = (char_code_i < gcsc_pkg::NARROW_FIRST) ||
                        (char_code_i >= gcsc_pkg::NARROW_END);

  always_comb begin
    item_o.code  = char_code_i;
    item_o.pause = pause_open_i;
    if (mode_i) begin
      item_o.kind = gcsc_pkg::KIND_TICK;
    end else if (!wide_mode_i && out_of_range) begin
      item_o.kind = gcsc_pkg::KIND_REJECT;
    end else begin
      item_o.kind = gcsc_pkg::KIND_LOOKUP;
    end
  end

  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

endmodule

### rtl/core/gcsc_queue.sv
// ---------------------------------------------------------------------------
// gcsc_queue
// Short FIFO of classified words between the front and back parts.
// ---------------------------------------------------------------------------
module gcsc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  gcsc_pkg::item_t item_i,
  input  logic            pop_i,
  output gcsc_pkg::item_t head_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int PTR_W = (gcsc_pkg::QDEPTH > 1) ? $clog2(gcsc_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(gcsc_pkg::QDEPTH + 1);

  gcsc_pkg::item_t  slots_q [gcsc_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(gcsc_pkg::QDEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(gcsc_pkg::QDEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/core/gcsc_back.sv
// ---------------------------------------------------------------------------
// gcsc_back
// Executes queued words: slot scan over the code store, append, fill reset.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gcsc_back #(
  parameter int SLOT_COUNT = gcsc_pkg::SLOT_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gcsc_pkg::item_t   item_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output gcsc_pkg::result_t res_o
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int SW    = gcsc_pkg::SLOT_W;
  localparam int CW    = gcsc_pkg::CODE_W;
  localparam logic [CNT_W-1:0] SLOT_MAX = CNT_W'(SLOT_COUNT);

  gcsc_pkg::bk_state_e state_q, state_d;

  logic [CW-1:0]    mem_q [SLOT_COUNT];
  logic [CW-1:0]    rd_data_q;
  logic [CW-1:0]    code_q, code_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             was_open_q, was_open_d;
  logic             res_valid_q, res_valid_d;
  gcsc_pkg::result_t res_q, res_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [CW-1:0]    mem_wdata;
  logic [CNT_W-1:0] idx_next_cnt;
  logic             match, last;

  assign idx_next_cnt = CNT_W'(idx_q) + CNT_W'(1);
  assign match        = (rd_data_q == code_q);
  assign last         = (idx_next_cnt == fill_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gcsc_pkg::BK_IDLE: begin
        if (!empty_i && item_i.kind == gcsc_pkg::KIND_LOOKUP && fill_q != '0) begin
          state_d = gcsc_pkg::BK_FETCH;
        end
      end
      gcsc_pkg::BK_FETCH: state_d = gcsc_pkg::BK_CMP;
      gcsc_pkg::BK_CMP: begin
        state_d = (match || last) ? gcsc_pkg::BK_IDLE : gcsc_pkg::BK_FETCH;
      end
      default: state_d = gcsc_pkg::BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pop_o       = 1'b0;
    res_valid_d = 1'b0;
    res_d       = '0;
    fill_d      = fill_q;
    was_open_d  = was_open_q;
    code_d      = code_q;
    idx_d       = idx_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_q[IDX_W-1:0];
    mem_wdata   = code_q;
    case (state_q)
      gcsc_pkg::BK_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (item_i.kind)
            gcsc_pkg::KIND_TICK: begin
              if (!(item_i.pause && was_open_q)) begin
                fill_d = '0;
              end
              was_open_d = item_i.pause;
            end
            gcsc_pkg::KIND_REJECT: begin
              res_valid_d = 1'b1;
            end
            gcsc_pkg::KIND_LOOKUP: begin
              if (fill_q == '0) begin
                // empty store: append straight into slot 0
                mem_we           = 1'b1;
                mem_waddr        = '0;
                mem_wdata        = item_i.code;
                fill_d           = CNT_W'(1);
                res_valid_d      = 1'b1;
                res_d.hit_valid  = 1'b1;
                res_d.needs_load = 1'b1;
              end else begin
                code_d = item_i.code;
                idx_d  = '0;
              end
            end
            default: ;
          endcase
        end
      end
      gcsc_pkg::BK_CMP: begin
        if (match) begin
          res_valid_d      = 1'b1;
          res_d.hit_valid  = 1'b1;
          res_d.slot_index = SW'(idx_q);
        end else if (last) begin
          res_valid_d = 1'b1;
          if (fill_q < SLOT_MAX) begin
            mem_we           = 1'b1;
            fill_d           = fill_q + CNT_W'(1);
            res_d.hit_valid  = 1'b1;
            res_d.slot_index = SW'(fill_q);
            res_d.needs_load = 1'b1;
          end
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcsc_pkg::BK_IDLE;
      fill_q      <= '0;
      was_open_q  <= 1'b0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      was_open_q  <= was_open_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    res_q  <= res_d;
  end

  // Code store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == gcsc_pkg::BK_FETCH) begin
      rd_data_q <= mem_q[idx_q];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `GCSC_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= SLOT_MAX,
                   "fill count beyond slot count")
  `GCSC_ASSERT_NOW(a_fetch_in_fill, clk_i, rst_ni, state_q == gcsc_pkg::BK_FETCH,
                   CNT_W'(idx_q) < fill_q, "scan index outside filled slots")
  `GCSC_ASSERT_NOW(a_load_appends, clk_i, rst_ni, res_valid_q && res_q.needs_load,
                   fill_q == CNT_W'($past(fill_q) + CNT_W'(1)),
                   "new slot reported without fill count step")
  `GCSC_ASSERT_NOW(a_pop_idle, clk_i, rst_ni, pop_o,
                   state_q == gcsc_pkg::BK_IDLE && !empty_i,
                   "word taken from queue outside idle")

endmodule

### rtl/core/glyph_code_slot_cache_top.sv
// ---------------------------------------------------------------------------
// glyph_code_slot_cache_top
// Append-only fully associative map from character codes to glyph slots.
// ---------------------------------------------------------------------------
// A command word is taken when start_i is high and busy_o is low; busy_o only
// rises when the two-word queue behind the front end is full, so a word can
// be issued while an earlier one is still being worked on. A lookup
// (mode_i = 0) gives exactly one result, a tick (mode_i = 1) gives none.
// Each result sits on hit_valid_o / slot_index_o / needs_load_o for exactly
// one cycle with done_o high; there is no back-pressure on the result side,
// so the consumer must capture it in that cycle. Results come in word order.
// Handling per word in the back end: a tick, a rejected code, or a lookup
// into an empty store is dealt with in the idle state as the word is taken
// from the queue; any other lookup runs the slot scan, comparing slots in
// order up to and including the first match, or the whole fill count on a
// miss. The code store is a single-read-port memory with registered read
// data, so each slot is first fetched (BK_FETCH) and then compared (BK_CMP).
// The result appears in the cycle after the deciding cycle. wide_mode is
// written through cfg_valid_i / cfg_data_i, always ready; write it only
// while no word is in flight.
// ---------------------------------------------------------------------------
module glyph_code_slot_cache_top #(
  parameter int SLOT_COUNT = gcsc_pkg::SLOT_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command words
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic [gcsc_pkg::CODE_W-1:0]   char_code_i,
  input  logic                          pause_open_i,
  // results
  output logic                          done_o,
  output logic                          hit_valid_o,
  output logic [gcsc_pkg::SLOT_W-1:0]   slot_index_o,
  output logic                          needs_load_o,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i
);

  logic              wide_mode_q;
  logic              q_full, q_empty, push, pop;
  gcsc_pkg::item_t   front_item, head_item;
  gcsc_pkg::result_t res;

  // wide_mode register; the port never stalls
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      wide_mode_q <= cfg_data_i;
    end
  end

  // Front: range check and classification happen at accept time
  gcsc_front u_front (
    .start_i      (start_i),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .pause_open_i (pause_open_i),
    .wide_mode_i  (wide_mode_q),
    .q_full_i     (q_full),
    .busy_o       (busy_o),
    .push_o       (push),
    .item_o       (front_item)
  );

  // Decoupling queue
  gcsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back: slot scan, append and tick handling
  gcsc_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (head_item),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .res_valid_o (done_o),
    .res_o       (res)
  );

  assign hit_valid_o  = res.hit_valid;
  assign slot_index_o = res.slot_index;
  assign needs_load_o = res.needs_load;

endmodule

### tb/sv/glyph_code_slot_cache_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// glyph_code_slot_cache_top_tb
// Self-checking bench for the glyph code slot cache: a directed table of
// command words, then random bursts in narrow and wide mode, each result
// checked field by field against a cycle-free model of the slot store.
// ---------------------------------------------------------------------------
module glyph_code_slot_cache_top_tb;

  // Command word kinds.
  localparam bit MODE_LOOKUP = 1'b0;
  localparam bit MODE_TICK   = 1'b1;

  // Sized for the longest lookup scan, over every slot; three words can be in
  // flight (the two-word queue plus the back end), so allow for all three.
  localparam int DRAIN_CYCLES = 800;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASES       = 4;
  localparam int PHASE_WORDS  = 170;
  localparam int QUIET_WORDS  = 100;   // final words sent with no gaps

  // One row of the directed table. Where fixed is set, res is the result
  // typed in by hand; otherwise the model supplies it.
  typedef struct packed {
    bit                          tick;
    logic [gcsc_pkg::CODE_W-1:0] code;
    bit                          pause;
    bit                          fixed;
    gcsc_pkg::result_t           res;
  } dir_word_t;

  localparam int N_DIRECTED = 20;
  localparam dir_word_t DIRECTED [N_DIRECTED] = '{
    // first narrow code into an empty store
    '{MODE_LOOKUP, 16'h0020, 1'b0, 1'b1, '{1'b1, 7'd0, 1'b1}},
    // just below the narrow range
    '{MODE_LOOKUP, 16'h001F, 1'b1, 1'b1, '{1'b0, 7'd0, 1'b0}},
    // last narrow code
    '{MODE_LOOKUP, 16'h00AF, 1'b0, 1'b1, '{1'b1, 7'd1, 1'b1}},
    // just above the narrow range, then both code extremes
    '{MODE_LOOKUP, 16'h00B0, 1'b0, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h0000, 1'b0, 1'b1, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'hFFFF, 1'b1, 1'b1, '{1'b0, 7'd0, 1'b0}},
    // hit on slot 0; pause_open is don't-care on a lookup
    '{MODE_LOOKUP, 16'h0020, 1'b1, 1'b1, '{1'b1, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h00AF, 1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
    // menu opens, was shut before: fill cleared, code ignored
    '{MODE_TICK,   16'hFFFF, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h0041, 1'b0, 1'b1, '{1'b1, 7'd0, 1'b1}},
    // menu open twice running: fill kept
    '{MODE_TICK,   16'h0000, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h0042, 1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h0041, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}},
    // menu shuts, then opens again: both clear
    '{MODE_TICK,   16'h5A5A, 1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_TICK,   16'hA5A5, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h0050, 1'b0, 1'b1, '{1'b1, 7'd0, 1'b1}},
    '{MODE_TICK,   16'h0050, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_TICK,   16'h0051, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h0050, 1'b0, 1'b0, '{1'b0, 7'd0, 1'b0}},
    '{MODE_LOOKUP, 16'h0051, 1'b1, 1'b0, '{1'b0, 7'd0, 1'b0}}
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic                          mode_i = 1'b0;
  logic [gcsc_pkg::CODE_W-1:0]   char_code_i = '0;
  logic                          pause_open_i = 1'b0;
  logic                          done_o;
  logic                          hit_valid_o;
  logic [gcsc_pkg::SLOT_W-1:0]   slot_index_o;
  logic                          needs_load_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic                          cfg_data_i = 1'b0;

  glyph_code_slot_cache_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .pause_open_i (pause_open_i),
    .done_o       (done_o),
    .hit_valid_o  (hit_valid_o),
    .slot_index_o (slot_index_o),
    .needs_load_o (needs_load_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---- slot store model ----------------------------------------------------
  logic [gcsc_pkg::CODE_W-1:0] code_store [gcsc_pkg::SLOT_COUNT];
  int unsigned                 fill_level;
  bit                          menu_was_open;
  bit                          wide_mode;

  gcsc_pkg::result_t expected_slots [$];

  int errors;
  int words_sent;
  int cycles;
  int n_lookups, n_ticks, n_hits, n_loads, n_range_rejects, n_full_rejects;

  // Applies one accepted word to the model; returns 1 when it gives a result.
  function automatic bit slot_predict(input bit m,
                                      input logic [gcsc_pkg::CODE_W-1:0] c,
                                      input bit p,
                                      output gcsc_pkg::result_t r);
    int unsigned k;
    r = '0;
    if (m == MODE_TICK) begin
      // fill survives only when the menu is open on this tick and the last
      if (!(p && menu_was_open)) fill_level = 0;
      menu_was_open = p;
      n_ticks++;
      return 1'b0;
    end
    n_lookups++;
    if (!wide_mode && (c < gcsc_pkg::NARROW_FIRST || c >= gcsc_pkg::NARROW_END)) begin
      n_range_rejects++;
      return 1'b1;
    end
    // lowest matching slot wins
    for (k = 0; k < fill_level; k++) begin
      if (code_store[k] == c) begin
        r.hit_valid  = 1'b1;
        r.slot_index = k[gcsc_pkg::SLOT_W-1:0];
        n_hits++;
        return 1'b1;
      end
    end
    if (fill_level >= gcsc_pkg::SLOT_COUNT) begin
      n_full_rejects++;
      return 1'b1;
    end
    code_store[fill_level] = c;
    r.hit_valid  = 1'b1;
    r.slot_index = fill_level[gcsc_pkg::SLOT_W-1:0];
    r.needs_load = 1'b1;
    fill_level++;
    n_loads++;
    return 1'b1;
  endfunction

  // ---- command side ----------------------------------------------------------
  // Drives one word at the falling edge, waits for the handshake, then books
  // the expected result. Short gaps go in front of words until the quiet tail.
  task automatic send_word(input bit m, input logic [gcsc_pkg::CODE_W-1:0] c,
                           input bit p, input bit fixed,
                           input gcsc_pkg::result_t fixed_res);
    gcsc_pkg::result_t r;
    bit                has;
    if (words_sent < N_DIRECTED + PHASES * PHASE_WORDS - QUIET_WORDS &&
        $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i      <= 1'b1;
    mode_i       <= m;
    char_code_i  <= c;
    pause_open_i <= p;
    do @(posedge clk_i); while (busy_o);
    has = slot_predict(m, c, p, r);
    if (has) expected_slots.push_back(fixed ? fixed_res : r);
    words_sent++;
  endtask

  // wide_mode may only change with nothing in flight; ticks leave no result
  // behind, so the full scan latency is waited out before the write.
  task automatic write_wide_mode(input bit v);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    wide_mode = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [gcsc_pkg::CODE_W-1:0] fresh_code();
    if (wide_mode) begin
      case ($urandom_range(0, 7))
        0:       return '0;
        1:       return '1;
        default: return gcsc_pkg::CODE_W'($urandom_range(0, 16'hFFFF));
      endcase
    end
    return gcsc_pkg::NARROW_FIRST + gcsc_pkg::CODE_W'($urandom_range(0, 143));
  endfunction

  // In narrow mode something outside the window; in wide mode anything goes.
  function automatic logic [gcsc_pkg::CODE_W-1:0] stray_code();
    if (wide_mode) return gcsc_pkg::CODE_W'($urandom_range(0, 16'hFFFF));
    if ($urandom_range(0, 1) == 0) return gcsc_pkg::CODE_W'($urandom_range(0, 'h1F));
    return gcsc_pkg::CODE_W'($urandom_range('hB0, 'hFFFF));
  endfunction

  task automatic run_random_phase(input int n);
    int                          sent;
    int                          roll;
    int                          len;
    int                          j;
    logic [gcsc_pkg::CODE_W-1:0] base;
    logic [gcsc_pkg::CODE_W-1:0] c;
    sent = 0;
    while (sent < n) begin
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
        // run of distinct codes, long enough to reach a full store
        len  = $urandom_range(20, 130);
        if (len > n - sent) len = n - sent;
        base = gcsc_pkg::CODE_W'($urandom_range(0, 16'hFFFF));
        for (j = 0; j < len; j++) begin
          if (wide_mode) c = base + gcsc_pkg::CODE_W'(j);
          else c = gcsc_pkg::NARROW_FIRST + gcsc_pkg::CODE_W'((base % 144 + j) % 144);
          send_word(MODE_LOOKUP, c, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end else if (roll < 5) begin
        // codes already held: mostly hits
        len = $urandom_range(1, 8);
        if (len > n - sent) len = n - sent;
        for (j = 0; j < len; j++) begin
          c = (fill_level > 0) ? code_store[$urandom_range(0, fill_level - 1)]
                               : fresh_code();
          send_word(MODE_LOOKUP, c, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end else if (roll < 6) begin
        len = $urandom_range(1, 4);
        if (len > n - sent) len = n - sent;
        for (j = 0; j < len; j++)
          send_word(MODE_LOOKUP, stray_code(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else if (roll < 8) begin
        // ticks lean to an open menu so the fill often survives
        len = $urandom_range(1, 3);
        if (len > n - sent) len = n - sent;
        for (j = 0; j < len; j++)
          send_word(MODE_TICK, gcsc_pkg::CODE_W'($urandom_range(0, 16'hFFFF)),
                    $urandom_range(0, 3) != 0, 1'b0, '0);
      end else begin
        len = $urandom_range(1, 6);
        if (len > n - sent) len = n - sent;
        for (j = 0; j < len; j++)
          send_word(MODE_LOOKUP, fresh_code(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      sent += len;
    end
  endtask

  // ---- result side -----------------------------------------------------------
  always @(posedge clk_i) begin
    gcsc_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (expected_slots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: hit %0b slot %0d load %0b", $time,
                 hit_valid_o, slot_index_o, needs_load_o);
      end else begin
        want = expected_slots.pop_front();
        if (hit_valid_o !== want.hit_valid) begin
          errors++;
          $display("%0t: hit_valid expected %0b got %0b", $time,
                   want.hit_valid, hit_valid_o);
        end
        if (slot_index_o !== want.slot_index) begin
          errors++;
          $display("%0t: slot_index expected %0d got %0d", $time,
                   want.slot_index, slot_index_o);
        end
        if (needs_load_o !== want.needs_load) begin
          errors++;
          $display("%0t: needs_load expected %0b got %0b", $time,
                   want.needs_load, needs_load_o);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               expected_slots.size());
      $display("glyph_code_slot_cache_top_tb failed");
      $finish;
    end
  end

  // ---- sequence --------------------------------------------------------------
  initial begin
    int i;
    fill_level    = 0;
    menu_was_open = 1'b0;
    wide_mode     = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // narrow mode straight out of reset
    for (i = 0; i < N_DIRECTED; i++)
      send_word(DIRECTED[i].tick, DIRECTED[i].code, DIRECTED[i].pause,
                DIRECTED[i].fixed, DIRECTED[i].res);

    // wide, narrow, wide, narrow
    for (i = 0; i < PHASES; i++) begin
      write_wide_mode(i % 2 == 0);
      run_random_phase(PHASE_WORDS);
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words: %0d lookups, %0d ticks, over %0d mode settings.",
             words_sent, n_lookups, n_ticks, PHASES + 1);
    $display("Lookups: %0d hits, %0d loads, %0d out of range, %0d on a full store.",
             n_hits, n_loads, n_range_rejects, n_full_rejects);
    if (errors == 0) begin
      $display("glyph_code_slot_cache_top_tb passed");
    end else begin
      $display("glyph_code_slot_cache_top_tb failed");
    end
    $finish;
  end

endmodule
